// ===== src/mtt_pkg.sv =====
// Shared types, constants and the tanh lookup table of the tanh perceptron core.
package mtt_pkg;

  localparam int ACT_W = 13;
  localparam int WEIGHT_W = 16;
  localparam int SENSOR_W = 16;
  localparam int INDEX_W = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int OFFSET_Q11 = 410;
  localparam int TANH_SPAN = 8192;
  localparam int TANH_ONE = 2048;

  typedef logic signed [ACT_W-1:0] act_t;
  typedef act_t tanh_rom_t [256];

  typedef struct packed {
    logic                       infer;
    logic [INDEX_W-1:0]         index;
    logic signed [WEIGHT_W-1:0] value;
    act_t                       act_a;
    act_t                       act_b;
  } mtt_entry_t;

  // Shift-and-subtract division used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k holds round(2048*tanh(t)) at the center t of its 1/32 wide span.
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] v;
    logic [63:0] one;
    one = 64'd1 << 24;
    sum = '0;
    term = 64'd1 << 48;
    n = 64'd1;
    while (term != 0) begin
      sum = sum + term;
      term = udiv64(term >> 5, n);
      n = n + 64'd1;
    end
    q = (sum + (64'd1 << 23)) >> 24;
    q2 = (q * q + (64'd1 << 23)) >> 24;
    e = q;
    for (int m = 0; m < 128; m++) begin
      num = (e - one) * 64'd4096 + (e + one);
      den = 64'd2 * (e + one);
      v = udiv64(num, den);
      rom[128 + m] = v[ACT_W-1:0];
      rom[127 - m] = -v[ACT_W-1:0];
      e = (e * q2 + (64'd1 << 23)) >> 24;
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  // The argument must already be clamped to the closed span of plus or minus 4.0.
  function automatic act_t tanh_q11(input logic signed [14:0] x);
    logic [14:0] sh;
    sh = x + 15'sd8192;
    if (x >= 15'sd8192) begin
      return act_t'(TANH_ONE);
    end
    return TANH_ROM[sh[13:6]];
  endfunction

endpackage

// ===== src/mtt_front.sv =====
// Request front end: classifies requests and applies the input tanh stage.
module mtt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_action,
  input  logic [6:0]                    in_weight_index,
  input  logic signed [15:0]            in_weight_value,
  input  logic signed [15:0]            in_sensor_a,
  input  logic signed [15:0]            in_sensor_b,
  output logic                          q_push,
  input  logic                          q_full,
  output mtt_pkg::mtt_entry_t           q_entry,
  input  logic [7:0]                    store_depth_m1
);
  import mtt_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  logic       accept;
  logic       keep;
  mtt_entry_t ent_r;
  mtt_entry_t ent_nxt;

  // Below the table span the result is minus one, not the lowest table entry.
  function automatic act_t sensor_act(input logic signed [15:0] s);
    logic signed [16:0] t;
    logic signed [14:0] xc;
    t = {s[15], s} + 17'sd410;
    if (t < -17'sd8192) begin
      return -act_t'(TANH_ONE);
    end else if (t > 17'sd8192) begin
      xc = 15'sd8192;
    end else begin
      xc = t[14:0];
    end
    return tanh_q11(xc);
  endfunction

  assign in_full = vld_r && q_full;
  assign accept = in_push && !in_full;
  assign keep = in_action || ({1'b0, in_weight_index} <= store_depth_m1);
  assign q_push = vld_r && !q_full;
  assign q_entry = ent_r;

  always_comb begin
    ent_nxt.infer = in_action;
    ent_nxt.index = in_weight_index;
    ent_nxt.value = in_weight_value;
    ent_nxt.act_a = sensor_act(in_sensor_a);
    ent_nxt.act_b = sensor_act(in_sensor_b);
    vld_nxt = vld_r && q_full;
    if (accept && keep) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ===== src/mtt_queue.sv =====
// Short request queue between the front end and the compute engine.
module mtt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mtt_pkg::mtt_entry_t push_entry,
  output logic                vld,
  input  logic                pop,
  output mtt_pkg::mtt_entry_t head
);
  import mtt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mtt_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign vld = cnt_r != '0;
  assign head = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== src/mtt_back.sv =====
// Compute engine: weight store, multiply-accumulate pipeline and result register.
module mtt_back #(
  parameter int HIDDEN_COUNT = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_vld,
  input  mtt_pkg::mtt_entry_t    q_entry,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic signed [12:0]     out_drive_a,
  output logic signed [12:0]     out_drive_b
);
  import mtt_pkg::*;

  localparam int STORE_DEPTH = HIDDEN_COUNT * 4;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int NODE_W = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int ACC_W = 30 + $clog2(HIDDEN_COUNT);
  localparam int PROD_W = ACT_W + WEIGHT_W;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1024);
  localparam logic signed [ACC_W-1:0] SPAN_HI = ACC_W'(TANH_SPAN);
  localparam logic signed [ACC_W-1:0] SPAN_LO = -ACC_W'(TANH_SPAN);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HID   = 6'b000010,
    S_HWAIT = 6'b000100,
    S_OUT   = 6'b001000,
    S_OWAIT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic              first;
    logic              last;
    logic              out_phase;
    logic              oidx;
    logic [NODE_W-1:0] node;
  } tag_t;

  state_t state_r;
  state_t state_nxt;

  logic signed [WEIGHT_W-1:0] wmem [STORE_DEPTH];
  act_t                       hmem [HIDDEN_COUNT];

  logic [ADDR_W-1:0] waddr_r;
  logic [ADDR_W-1:0] waddr_nxt;
  logic [NODE_W-1:0] j_r;
  logic [NODE_W-1:0] j_nxt;
  logic              sub_r;
  logic              sub_nxt;
  act_t              act_a_r;
  act_t              act_b_r;

  logic              issue;
  logic              is_out;
  logic              last_j;
  logic              wr_en;
  logic              pipe_busy;
  logic              load_out;
  tag_t              tag_nxt;

  logic                       s1_v_r;
  tag_t                       s1_tag_r;
  act_t                       s1_act_r;
  logic signed [WEIGHT_W-1:0] w_q_r;
  act_t                       h_q_r;
  act_t                       s1_op;
  logic                       s2_v_r;
  tag_t                       s2_tag_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic                       s3_v_r;
  tag_t                       s3_tag_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [14:0]         xc;
  act_t                       th;

  act_t drv_a_r;
  act_t drv_b_r;
  logic out_vld_r;
  act_t out_a_r;
  act_t out_b_r;

  assign q_pop = (state_r == S_IDLE) && q_vld;
  assign wr_en = q_pop && !q_entry.infer;
  assign issue = (state_r == S_HID) || (state_r == S_OUT);
  assign is_out = state_r == S_OUT;
  assign last_j = j_r == NODE_W'(HIDDEN_COUNT - 1);
  assign pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign load_out = (state_r == S_DONE) && (!out_vld_r || out_pop);

  assign out_empty = !out_vld_r;
  assign out_drive_a = out_a_r;
  assign out_drive_b = out_b_r;

  always_comb begin
    tag_nxt.out_phase = is_out;
    tag_nxt.oidx = sub_r;
    tag_nxt.node = j_r;
    tag_nxt.first = is_out ? (j_r == '0) : !sub_r;
    tag_nxt.last = is_out ? last_j : sub_r;
  end

  always_comb begin
    state_nxt = state_r;
    waddr_nxt = waddr_r;
    j_nxt = j_r;
    sub_nxt = sub_r;
    case (state_r)
      S_IDLE: begin
        waddr_nxt = '0;
        j_nxt = '0;
        sub_nxt = 1'b0;
        if (q_pop && q_entry.infer) begin
          state_nxt = S_HID;
        end
      end
      S_HID: begin
        waddr_nxt = waddr_r + 1'b1;
        sub_nxt = !sub_r;
        if (sub_r) begin
          j_nxt = last_j ? '0 : j_r + 1'b1;
          if (last_j) begin
            state_nxt = S_HWAIT;
          end
        end
      end
      S_HWAIT: begin
        if (!pipe_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        waddr_nxt = waddr_r + 1'b1;
        j_nxt = last_j ? '0 : j_r + 1'b1;
        if (last_j) begin
          sub_nxt = 1'b1;
          if (sub_r) begin
            state_nxt = S_OWAIT;
          end
        end
      end
      S_OWAIT: begin
        if (!pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign s1_op = s1_tag_r.out_phase ? h_q_r : s1_act_r;
  assign prod_nxt = s1_op * w_q_r;

  always_comb begin
    rnd = (acc_r + RND_HALF) >>> 11;
    if (rnd < SPAN_LO) begin
      xc = -15'sd8192;
    end else if (rnd > SPAN_HI) begin
      xc = 15'sd8192;
    end else begin
      xc = rnd[14:0];
    end
    th = tanh_q11(xc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && s2_tag_r.last;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    waddr_r <= waddr_nxt;
    j_r <= j_nxt;
    sub_r <= sub_nxt;
    if (q_pop && q_entry.infer) begin
      act_a_r <= q_entry.act_a;
      act_b_r <= q_entry.act_b;
    end
    s1_tag_r <= tag_nxt;
    s1_act_r <= sub_r ? act_b_r : act_a_r;
    s2_tag_r <= s1_tag_r;
    prod_r <= prod_nxt;
    if (s2_v_r) begin
      s3_tag_r <= s2_tag_r;
      acc_r <= s2_tag_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    if (s3_v_r && s3_tag_r.out_phase) begin
      if (s3_tag_r.oidx) begin
        drv_b_r <= th;
      end else begin
        drv_a_r <= th;
      end
    end
    if (load_out) begin
      out_a_r <= drv_a_r;
      out_b_r <= drv_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[ADDR_W'(q_entry.index)] <= q_entry.value;
    end
    w_q_r <= wmem[waddr_r];
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && !s3_tag_r.out_phase) begin
      hmem[s3_tag_r.node] <= th;
    end
    h_q_r <= hmem[j_r];
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !s1_v_r && !s2_v_r && !s3_v_r)
    else $error("MAC pipeline busy while engine is idle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_DONE))
    else $error("Result loaded outside the done state");

  a_sum_after_product: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> $past(s2_v_r && s2_tag_r.last))
    else $error("Finished sum without a closing product");

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (j_r <= NODE_W'(HIDDEN_COUNT - 1)))
    else $error("Node counter out of range");

endmodule

// ===== src/mlp_tanh_two_layer_inference_core.sv =====
// Top level of the two-layer tanh perceptron inference core.
// A weight write request goes into the weight store as the engine takes it from the queue. An
// inference request runs one multiply-accumulate per cycle through a single multiplier fed by the
// one read port of the weight store, 2*HIDDEN_COUNT of them for the hidden layer and
// 2*HIDDEN_COUNT for the output layer, plus the pipeline drain after each layer. The front end
// takes new requests into a short queue while the engine works, and a finished result waits in
// an output register until popped.
// Writes to entries at or beyond 4*HIDDEN_COUNT are dropped; entries are undefined until written.
module mlp_tanh_two_layer_inference_core #(
  parameter int HIDDEN_COUNT = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_action,
  input  logic [6:0]         in_weight_index,
  input  logic signed [15:0] in_weight_value,
  input  logic signed [15:0] in_sensor_a,
  input  logic signed [15:0] in_sensor_b,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [12:0] out_drive_a,
  output logic signed [12:0] out_drive_b
);
  import mtt_pkg::*;

  localparam logic [7:0] STORE_DEPTH_M1 = 8'(HIDDEN_COUNT * 4 - 1);

  logic       fq_push;
  logic       fq_full;
  mtt_entry_t fq_entry;
  logic       q_vld;
  logic       q_pop;
  mtt_entry_t q_head;

  mtt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .in_sensor_a     (in_sensor_a),
    .in_sensor_b     (in_sensor_b),
    .q_push          (fq_push),
    .q_full          (fq_full),
    .q_entry         (fq_entry),
    .store_depth_m1  (STORE_DEPTH_M1)
  );

  mtt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fq_push),
    .full       (fq_full),
    .push_entry (fq_entry),
    .vld        (q_vld),
    .pop        (q_pop),
    .head       (q_head)
  );

  mtt_back #(
    .HIDDEN_COUNT (HIDDEN_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_vld       (q_vld),
    .q_entry     (q_head),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_drive_a (out_drive_a),
    .out_drive_b (out_drive_b)
  );

endmodule
